/* sv/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths, register codes and payload types of the RGB to HSV red
// classifier.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   // Fraction bits of the hue output
   localparam int HUE_FRAC_BITS = 6;

   localparam int CH_W       = 8;   // color channel, value, saturation
   localparam int HUE_W      = 15;  // hue output field
   localparam int DEG_W      = 9;   // whole degrees (band registers)
   localparam int BASE_W     = 11;  // sector base, up to 6 * 255
   localparam int HNUM_W     = 17;  // hue numerator in degrees, up to 60 * 1530
   localparam int DIVN_W     = HNUM_W + HUE_FRAC_BITS;  // divider numerator
   localparam int RECIP_W    = DIVN_W + 1;              // reciprocal 2^DIVN_W / den
   localparam int PROD_W     = DIVN_W + RECIP_W;
   localparam int REM_W      = CH_W + 1;                // remainder below 2 * den
   localparam int TAB_DEPTH  = 1 << CH_W;
   localparam int IDX_W      = 4;
   localparam int CSR_DATA_W = 9;

   localparam int STAGES = 6;
   // Stage indexes of the pipeline
   localparam int ST_SORT  = 0;
   localparam int ST_BASE  = 1;
   localparam int ST_MUL   = 2;
   localparam int ST_REM   = 3;
   localparam int ST_FIX   = 4;
   localparam int ST_CLASS = 5;
   localparam int LANE_STAGES = 3;

   localparam logic [DIVN_W-1:0] FRAC_MASK = (DIVN_W'(1) << HUE_FRAC_BITS) - DIVN_W'(1);
   localparam int HUE_LIMIT = 360 << HUE_FRAC_BITS;

   typedef enum logic [IDX_W-1:0] {
      CSR_HUE_A_LO = 4'd0,
      CSR_HUE_A_HI = 4'd1,
      CSR_HUE_B_LO = 4'd2,
      CSR_HUE_B_HI = 4'd3,
      CSR_SAT_MIN  = 4'd4,
      CSR_SAT_MAX  = 4'd5,
      CSR_VAL_MIN  = 4'd6,
      CSR_VAL_MAX  = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [DEG_W-1:0] hue_a_lo;
      logic [DEG_W-1:0] hue_a_hi;
      logic [DEG_W-1:0] hue_b_lo;
      logic [DEG_W-1:0] hue_b_hi;
      logic [CH_W-1:0]  sat_min;
      logic [CH_W-1:0]  sat_max;
      logic [CH_W-1:0]  val_min;
      logic [CH_W-1:0]  val_max;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      hue_a_lo: 9'd270, hue_a_hi: 9'd360, hue_b_lo: 9'd0, hue_b_hi: 9'd20,
      sat_min: 8'd16, sat_max: 8'd255, val_min: 8'd46, val_max: 8'd255
   };

   // Operands handed from the front end to the two divider lanes
   typedef struct packed {
      logic [DIVN_W-1:0] hue_num;
      logic [CH_W-1:0]   hue_den;
      logic [DIVN_W-1:0] sat_num;
      logic [CH_W-1:0]   sat_den;
      logic [CH_W-1:0]   value;
   } front_type;

   // Quotient and exactness flag of one divider lane
   typedef struct packed {
      logic [DIVN_W-1:0] quot;
      logic              rem_nz;
   } quot_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  saturation;
      logic [CH_W-1:0]  value;
      logic             is_red;
   } result_type;

endpackage

/* sv/rgbhsv_if.sv */
// ----------------------------------------------------------------------------
// rgbhsv_if
// Valid/ready channel interfaces: pixel in, HSV result out, register write.
// ----------------------------------------------------------------------------
interface rgbhsv_req_if;
   logic                          valid;
   logic                          ready;
   logic [rgbhsv_pkg::CH_W-1:0]   red;
   logic [rgbhsv_pkg::CH_W-1:0]   green;
   logic [rgbhsv_pkg::CH_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rgbhsv_pkg::HUE_W-1:0]  hue;
   logic [rgbhsv_pkg::CH_W-1:0]   saturation;
   logic [rgbhsv_pkg::CH_W-1:0]   value;
   logic                          is_red;

   modport source (output valid, output hue, output saturation, output value,
                   output is_red, input ready);
   modport sink   (input valid, input hue, input saturation, input value,
                   input is_red, output ready);
endinterface

interface rgbhsv_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rgbhsv_pkg::IDX_W-1:0]        index;
   logic [rgbhsv_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/rgb_to_hsv_red_classifier.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_red_classifier
// Converts a stream of 8-bit RGB pixels to HSV and flags red pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch : one pixel (red, green, blue) per transfer.
//   rsp_ch : one result per pixel, in order: hue in degrees with 6 fraction
//            bits (truncated), saturation times 255 (truncated), value (the
//            largest channel) and is_red.
//   csr_ch : register writes (index 0..7 = hue band A low/high, hue band B
//            low/high, sat min/max, val min/max). Always ready; unknown
//            indexes are dropped. Write only while no pixel is in flight.
// Throughput is one pixel per cycle while rsp_ch is not stalled: the
// six-stage pipeline (sort, sector base, reciprocal multiply, remainder,
// quotient correction, window check) takes a new pixel each clock.
// A stalled rsp_ch holds the result stage; earlier stages keep filling any
// empty slot, and req_ready drops only when every stage holds a pixel.
// Reset empties the pipeline and loads the default thresholds
// (hue 270..360 or 0..20, saturation 16..255, value 46..255).
// ----------------------------------------------------------------------------
module rgb_to_hsv_red_classifier (
   input  logic            clock,
   input  logic            reset,
   rgbhsv_req_if.sink      req_ch,
   rgbhsv_rsp_if.source    rsp_ch,
   rgbhsv_csr_if.sink      csr_ch
);

   rgbhsv_pkg::cfg_type      cfg;
   rgbhsv_pkg::front_type    front;
   rgbhsv_pkg::quot_type     hue_q;
   rgbhsv_pkg::quot_type     sat_q;
   rgbhsv_pkg::result_type   result;

   logic [rgbhsv_pkg::STAGES-1:0]   valid_ff;
   logic [rgbhsv_pkg::STAGES-1:0]   valid_in;
   logic [rgbhsv_pkg::STAGES-1:0]   en;

   // Value rides alongside the divider lanes
   logic [rgbhsv_pkg::CH_W-1:0]     val_mul_ff;
   logic [rgbhsv_pkg::CH_W-1:0]     val_rem_ff;
   logic [rgbhsv_pkg::CH_W-1:0]     val_fix_ff;

   // A stage advances when it is empty or its successor advances
   always_comb begin
      en[rgbhsv_pkg::STAGES-1] = !valid_ff[rgbhsv_pkg::STAGES-1] || rsp_ch.ready;
      for (int i = rgbhsv_pkg::STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   // Valid bits move with the data; a held stage keeps its bit
   always_comb begin
      valid_in[0] = en[0] ? req_ch.valid : valid_ff[0];
      for (int i = 1; i < rgbhsv_pkg::STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ch.ready = en[rgbhsv_pkg::ST_SORT];

   rgbhsv_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   rgbhsv_front u_front (
      .clock (clock),
      .en    (en[rgbhsv_pkg::ST_BASE:rgbhsv_pkg::ST_SORT]),
      .red   (req_ch.red),
      .green (req_ch.green),
      .blue  (req_ch.blue),
      .front (front)
   );

   rgbhsv_div_lane u_hue_div (
      .clock  (clock),
      .en     (en[rgbhsv_pkg::ST_FIX:rgbhsv_pkg::ST_MUL]),
      .num    (front.hue_num),
      .den    (front.hue_den),
      .result (hue_q)
   );

   rgbhsv_div_lane u_sat_div (
      .clock  (clock),
      .en     (en[rgbhsv_pkg::ST_FIX:rgbhsv_pkg::ST_MUL]),
      .num    (front.sat_num),
      .den    (front.sat_den),
      .result (sat_q)
   );

   always_ff @(posedge clock) begin
      if (en[rgbhsv_pkg::ST_MUL]) begin
         val_mul_ff <= front.value;
      end
      if (en[rgbhsv_pkg::ST_REM]) begin
         val_rem_ff <= val_mul_ff;
      end
      if (en[rgbhsv_pkg::ST_FIX]) begin
         val_fix_ff <= val_rem_ff;
      end
   end

   rgbhsv_class u_class (
      .clock  (clock),
      .en     (en[rgbhsv_pkg::ST_CLASS]),
      .cfg    (cfg),
      .hue_q  (hue_q),
      .sat_q  (sat_q),
      .value  (val_fix_ff),
      .result (result)
   );

   // Drive the result channel straight from the last stage
   assign rsp_ch.valid      = valid_ff[rgbhsv_pkg::ST_CLASS];
   assign rsp_ch.hue        = result.hue;
   assign rsp_ch.saturation = result.saturation;
   assign rsp_ch.value      = result.value;
   assign rsp_ch.is_red     = result.is_red;

endmodule

/* sv/rgbhsv_csr.sv */
// ----------------------------------------------------------------------------
// rgbhsv_csr
// Threshold registers; a write to an unknown index is dropped.
// ----------------------------------------------------------------------------
module rgbhsv_csr (
   input  logic                 clock,
   input  logic                 reset,
   rgbhsv_csr_if.sink           csr_ch,
   output rgbhsv_pkg::cfg_type  cfg
);

   rgbhsv_pkg::cfg_type cfg_ff;
   rgbhsv_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (rgbhsv_pkg::csr_index_type'(csr_ch.index))
            rgbhsv_pkg::CSR_HUE_A_LO: cfg_in.hue_a_lo = csr_ch.data[rgbhsv_pkg::DEG_W-1:0];
            rgbhsv_pkg::CSR_HUE_A_HI: cfg_in.hue_a_hi = csr_ch.data[rgbhsv_pkg::DEG_W-1:0];
            rgbhsv_pkg::CSR_HUE_B_LO: cfg_in.hue_b_lo = csr_ch.data[rgbhsv_pkg::DEG_W-1:0];
            rgbhsv_pkg::CSR_HUE_B_HI: cfg_in.hue_b_hi = csr_ch.data[rgbhsv_pkg::DEG_W-1:0];
            rgbhsv_pkg::CSR_SAT_MIN:  cfg_in.sat_min  = csr_ch.data[rgbhsv_pkg::CH_W-1:0];
            rgbhsv_pkg::CSR_SAT_MAX:  cfg_in.sat_max  = csr_ch.data[rgbhsv_pkg::CH_W-1:0];
            rgbhsv_pkg::CSR_VAL_MIN:  cfg_in.val_min  = csr_ch.data[rgbhsv_pkg::CH_W-1:0];
            rgbhsv_pkg::CSR_VAL_MAX:  cfg_in.val_max  = csr_ch.data[rgbhsv_pkg::CH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rgbhsv_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/rgbhsv_front.sv */
// ----------------------------------------------------------------------------
// rgbhsv_front
// Two pipeline stages: sort the channels and pick the hue sector, then form
// the hue and saturation numerators and divisors.
// ----------------------------------------------------------------------------
module rgbhsv_front (
   input  logic                          clock,
   input  logic [1:0]                    en,
   input  logic [rgbhsv_pkg::CH_W-1:0]   red,
   input  logic [rgbhsv_pkg::CH_W-1:0]   green,
   input  logic [rgbhsv_pkg::CH_W-1:0]   blue,
   output rgbhsv_pkg::front_type         front
);

   typedef enum logic [1:0] {
      SEC_RED   = 2'd0,
      SEC_GREEN = 2'd1,
      SEC_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      sector_type                    sector;
      logic                          neg;
      logic [rgbhsv_pkg::CH_W-1:0]   adiff;
      logic [rgbhsv_pkg::CH_W-1:0]   mx;
      logic [rgbhsv_pkg::CH_W-1:0]   d;
   } sort_type;

   sort_type                sort_ff;
   sort_type                sort_in;
   rgbhsv_pkg::front_type   front_ff;
   rgbhsv_pkg::front_type   front_in;

   logic [rgbhsv_pkg::CH_W-1:0]   mx;
   logic [rgbhsv_pkg::CH_W-1:0]   mn;
   logic [rgbhsv_pkg::CH_W-1:0]   op_p;
   logic [rgbhsv_pkg::CH_W-1:0]   op_q;
   logic [rgbhsv_pkg::BASE_W-1:0] d_ext;
   logic [rgbhsv_pkg::BASE_W-1:0] a_ext;
   logic [rgbhsv_pkg::BASE_W-1:0] base;
   logic [rgbhsv_pkg::HNUM_W-1:0] hnum;
   logic [rgbhsv_pkg::DIVN_W-1:0] snum;

   // Stage 1: max, min and the sector difference (red wins ties, then green)
   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;

      if (red == mx) begin
         sort_in.sector = SEC_RED;
         op_p = green;
         op_q = blue;
      end else if (green == mx) begin
         sort_in.sector = SEC_GREEN;
         op_p = blue;
         op_q = red;
      end else begin
         sort_in.sector = SEC_BLUE;
         op_p = red;
         op_q = green;
      end
      sort_in.neg   = op_p < op_q;
      sort_in.adiff = sort_in.neg ? (op_q - op_p) : (op_p - op_q);
      sort_in.mx    = mx;
      sort_in.d     = mx - mn;
   end

   // Stage 2: base = k*d +/- diff, hue numerator 60*base; gray and black
   // pixels already give zero numerators, so only the divisors need forcing
   always_comb begin
      d_ext = rgbhsv_pkg::BASE_W'(sort_ff.d);
      a_ext = rgbhsv_pkg::BASE_W'(sort_ff.adiff);
      case (sort_ff.sector)
         SEC_RED:   base = sort_ff.neg ? ((d_ext << 2) + (d_ext << 1) - a_ext) : a_ext;
         SEC_GREEN: base = sort_ff.neg ? ((d_ext << 1) - a_ext) : ((d_ext << 1) + a_ext);
         SEC_BLUE:  base = sort_ff.neg ? ((d_ext << 2) - a_ext) : ((d_ext << 2) + a_ext);
         default:   base = '0;
      endcase
      hnum = (rgbhsv_pkg::HNUM_W'(base) << 6) - (rgbhsv_pkg::HNUM_W'(base) << 2);
      snum = (rgbhsv_pkg::DIVN_W'(sort_ff.d) << rgbhsv_pkg::CH_W)
             - rgbhsv_pkg::DIVN_W'(sort_ff.d);

      front_in.hue_num = rgbhsv_pkg::DIVN_W'(hnum) << rgbhsv_pkg::HUE_FRAC_BITS;
      front_in.sat_num = snum;
      front_in.value   = sort_ff.mx;
      if (sort_ff.d == '0) begin
         front_in.hue_den = rgbhsv_pkg::CH_W'(1);
         front_in.sat_den = rgbhsv_pkg::CH_W'(1);
      end else begin
         front_in.hue_den = sort_ff.d;
         front_in.sat_den = sort_ff.mx;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sort_ff <= sort_in;
      end
      if (en[1]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

/* sv/rgbhsv_div_lane.sv */
// ----------------------------------------------------------------------------
// rgbhsv_div_lane
// Three-stage exact divider for an 8-bit divisor: reciprocal multiply,
// back-multiply for the remainder, one correction step.
// ----------------------------------------------------------------------------
module rgbhsv_div_lane (
   input  logic                                  clock,
   input  logic [rgbhsv_pkg::LANE_STAGES-1:0]    en,
   input  logic [rgbhsv_pkg::DIVN_W-1:0]         num,
   input  logic [rgbhsv_pkg::CH_W-1:0]           den,
   output rgbhsv_pkg::quot_type                  result
);

   // floor(2^DIVN_W / i); entry 0 is never selected
   logic [rgbhsv_pkg::RECIP_W-1:0] recip_tab [rgbhsv_pkg::TAB_DEPTH];

   for (genvar i = 0; i < rgbhsv_pkg::TAB_DEPTH; i++) begin : g_recip
      localparam logic [63:0] RecipVal =
         (64'd1 << rgbhsv_pkg::DIVN_W) / ((i == 0) ? 64'd1 : 64'(i));
      assign recip_tab[i] = rgbhsv_pkg::RECIP_W'(RecipVal);
   end

   logic [rgbhsv_pkg::DIVN_W-1:0]         num_a_ff;
   logic [rgbhsv_pkg::CH_W-1:0]           den_a_ff;
   logic [rgbhsv_pkg::DIVN_W-1:0]         qest_a_ff;
   logic [rgbhsv_pkg::PROD_W-1:0]         prod;

   logic [rgbhsv_pkg::CH_W-1:0]           den_b_ff;
   logic [rgbhsv_pkg::DIVN_W-1:0]         qest_b_ff;
   logic [rgbhsv_pkg::REM_W-1:0]          rem_b_ff;
   logic [rgbhsv_pkg::DIVN_W+rgbhsv_pkg::CH_W-1:0] back;
   logic [rgbhsv_pkg::DIVN_W-1:0]         diff;

   rgbhsv_pkg::quot_type                  result_ff;
   rgbhsv_pkg::quot_type                  result_in;

   // Estimate is the true quotient or one below it
   assign prod = rgbhsv_pkg::PROD_W'(num) * rgbhsv_pkg::PROD_W'(recip_tab[den]);

   // Remainder stays below 2*den, so its low bits are exact
   assign back = (rgbhsv_pkg::DIVN_W + rgbhsv_pkg::CH_W)'(qest_a_ff)
                 * (rgbhsv_pkg::DIVN_W + rgbhsv_pkg::CH_W)'(den_a_ff);
   assign diff = num_a_ff - back[rgbhsv_pkg::DIVN_W-1:0];

   always_comb begin
      if (rem_b_ff >= rgbhsv_pkg::REM_W'(den_b_ff)) begin
         result_in.quot   = qest_b_ff + rgbhsv_pkg::DIVN_W'(1);
         result_in.rem_nz = (rem_b_ff - rgbhsv_pkg::REM_W'(den_b_ff)) != '0;
      end else begin
         result_in.quot   = qest_b_ff;
         result_in.rem_nz = rem_b_ff != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         num_a_ff  <= num;
         den_a_ff  <= den;
         qest_a_ff <= prod[rgbhsv_pkg::DIVN_W +: rgbhsv_pkg::DIVN_W];
      end
      if (en[1]) begin
         den_b_ff  <= den_a_ff;
         qest_b_ff <= qest_a_ff;
         rem_b_ff  <= diff[rgbhsv_pkg::REM_W-1:0];
      end
      if (en[2]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* sv/rgbhsv_class.sv */
// ----------------------------------------------------------------------------
// rgbhsv_class
// Last stage: window checks on the exact hue and saturation, and the
// result register.
// ----------------------------------------------------------------------------
module rgbhsv_class (
   input  logic                          clock,
   input  logic                          en,
   input  rgbhsv_pkg::cfg_type           cfg,
   input  rgbhsv_pkg::quot_type          hue_q,
   input  rgbhsv_pkg::quot_type          sat_q,
   input  logic [rgbhsv_pkg::CH_W-1:0]   value,
   output rgbhsv_pkg::result_type        result
);

   // lo <= x <= hi for x = whole + fraction; exact tells the fraction is zero
   function automatic logic in_window(
      input logic [rgbhsv_pkg::DEG_W-1:0] whole,
      input logic                         exact,
      input logic [rgbhsv_pkg::DEG_W-1:0] lo,
      input logic [rgbhsv_pkg::DEG_W-1:0] hi
   );
      return (whole >= lo) && ((whole < hi) || ((whole == hi) && exact));
   endfunction

   rgbhsv_pkg::result_type          result_ff;
   rgbhsv_pkg::result_type          result_in;
   logic [rgbhsv_pkg::DEG_W-1:0]    hue_deg;
   logic                            hue_exact;
   logic [rgbhsv_pkg::DEG_W-1:0]    sat_whole;
   logic                            hue_ok;
   logic                            sat_ok;
   logic                            val_ok;

   always_comb begin
      hue_deg   = rgbhsv_pkg::DEG_W'(hue_q.quot >> rgbhsv_pkg::HUE_FRAC_BITS);
      hue_exact = !hue_q.rem_nz && ((hue_q.quot & rgbhsv_pkg::FRAC_MASK) == '0);
      sat_whole = rgbhsv_pkg::DEG_W'(sat_q.quot[rgbhsv_pkg::CH_W-1:0]);

      hue_ok = in_window(hue_deg, hue_exact, cfg.hue_a_lo, cfg.hue_a_hi)
            || in_window(hue_deg, hue_exact, cfg.hue_b_lo, cfg.hue_b_hi);
      sat_ok = in_window(sat_whole, !sat_q.rem_nz,
                         rgbhsv_pkg::DEG_W'(cfg.sat_min), rgbhsv_pkg::DEG_W'(cfg.sat_max));
      val_ok = (value >= cfg.val_min) && (value <= cfg.val_max);

      result_in.hue        = rgbhsv_pkg::HUE_W'(hue_q.quot);
      result_in.saturation = sat_q.quot[rgbhsv_pkg::CH_W-1:0];
      result_in.value      = value;
      result_in.is_red     = hue_ok && sat_ok && val_ok;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* sv/rgbhsv_checker.sv */
// ----------------------------------------------------------------------------
// rgbhsv_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module rgbhsv_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [rgbhsv_pkg::HUE_W-1:0]  rsp_hue,
   input  logic [rgbhsv_pkg::CH_W-1:0]   rsp_saturation,
   input  logic [rgbhsv_pkg::CH_W-1:0]   rsp_value,
   input  logic                          rsp_is_red
);

   // Reset empties the pipeline and opens the input
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_hue, rsp_saturation, rsp_value, rsp_is_red}))
      else $error("stalled result changed");

   // Black pixel gets zero hue and zero saturation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value == '0 |-> rsp_hue == '0 && rsp_saturation == '0)
      else $error("black pixel with nonzero hue or saturation");

   // Hue stays below 360 degrees
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rgbhsv_pkg::HUE_LIMIT >= (1 << rgbhsv_pkg::HUE_W))
         || (int'(rsp_hue) < rgbhsv_pkg::HUE_LIMIT))
      else $error("hue out of range");

endmodule

bind rgb_to_hsv_red_classifier rgbhsv_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_hue        (rsp_ch.hue),
   .rsp_saturation (rsp_ch.saturation),
   .rsp_value      (rsp_ch.value),
   .rsp_is_red     (rsp_ch.is_red)
);
